>>> rtl/thss_pkg.sv
// ----------------------------------------------------------------------------
// thss_pkg
// Types, constants and helpers shared by the trace header sync search files.
// ----------------------------------------------------------------------------
package thss_pkg;

  // Width of the nibble position counter (8 to 32).
  localparam int POSITION_BITS = 16;
  localparam int OFFSET_BITS   = 16;

  localparam logic [3:0] NIBBLE_ZERO  = 4'h0;
  localparam logic [3:0] MASTER_OP    = 4'h1;
  localparam logic [3:0] CHANNEL_OP   = 4'h3;
  localparam logic [3:0] DATA_OP_MIN  = 4'h4;
  localparam logic [3:0] DATA_OP_MAX  = 4'hB;
  localparam logic [1:0] SKIP_COUNT   = 2'd2;
  localparam logic [1:0] ZERO_RUN     = 2'd3;

  typedef enum logic [6:0] {
    PH_ZERO    = 7'b0000001,
    PH_OPCODE  = 7'b0000010,
    PH_MSKIP   = 7'b0000100,
    PH_CHANNEL = 7'b0001000,
    PH_CSKIP   = 7'b0010000,
    PH_DATA    = 7'b0100000,
    PH_FOUND   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic                   hdr_found;
    logic [OFFSET_BITS-1:0] header_offset;
    logic [3:0]             data_opcode;
  } out_item_t;

  typedef struct packed {
    phase_t                   phase;
    logic [1:0]               zeros_seen;
    logic [1:0]               nibbles_to_skip;
    logic [POSITION_BITS-1:0] position;
    logic [POSITION_BITS-1:0] start_offset;
    logic [3:0]               found_opcode;
  } search_state_t;

  function automatic logic is_data_opcode(logic [3:0] c);
    return c inside {[DATA_OP_MIN:DATA_OP_MAX]};
  endfunction

endpackage

>>> rtl/trace_header_sync_search_unit.sv
// ----------------------------------------------------------------------------
// trace_header_sync_search_unit
// Nibble-serial search for a trace packet header with a held result.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid / in_stall / in_item (nibble, restart). One item per
//                 nibble of the trace stream, in search order.
//   out channel : out_valid / out_stall / out_item (hdr_found,
//                 header_offset, data_opcode). Exactly one result item per
//                 input item, in order.
//   wr_en/wr_data: writes skip_zero_hunt; write only while the block is idle.
// Path: an accepted item is held in the input register, stepped through the
//   search logic, and moves to the result register when that register is
//   empty or being drained; out_valid shows it from then on.
// Throughput: one item per cycle while out_stall is low; the search step is a
//   single pass of small state logic between the input and result registers.
// Stall: a result waiting under out_stall keeps one more item parked in the
//   input register; only then does in_stall rise.
// Reset: rst (synchronous) empties both registers, clears the search state
//   and position, and clears skip_zero_hunt.
// ----------------------------------------------------------------------------
module trace_header_sync_search_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic                wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  thss_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output thss_pkg::out_item_t out_item
);
  import thss_pkg::*;

  logic          skip_zero_hunt;

  // input register
  logic          s1_valid;
  in_item_t      s1_item;

  // search state, advanced only when an item moves to the result register
  search_state_t state;
  search_state_t state_next;
  out_item_t     result_next;

  logic          advance;
  logic          take_in;

  // s1 moves on whenever the result register is empty or being drained
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign take_in  = in_valid && !in_stall;

  thss_step u_step (
    .cur            (state),
    .item           (s1_item),
    .skip_zero_hunt (skip_zero_hunt),
    .nxt            (state_next),
    .result         (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_zero_hunt <= 1'b0;
    end else if (wr_en) begin
      skip_zero_hunt <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take_in) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase           <= PH_ZERO;
      state.zeros_seen      <= '0;
      state.nibbles_to_skip <= '0;
      state.position        <= '0;
      state.start_offset    <= '0;
      state.found_opcode    <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result_next;
    end
  end

endmodule

>>> rtl/thss_step.sv
// ----------------------------------------------------------------------------
// thss_step
// One search step: next search state and result for one nibble.
// ----------------------------------------------------------------------------
module thss_step (
  input  thss_pkg::search_state_t cur,
  input  thss_pkg::in_item_t      item,
  input  logic                    skip_zero_hunt,
  output thss_pkg::search_state_t nxt,
  output thss_pkg::out_item_t     result
);
  import thss_pkg::*;

  phase_t     eff;
  logic       brk;
  logic [1:0] zs;
  logic [1:0] nts;
  logic [31:0] off_wide;

  always_comb begin
    nxt      = cur;
    brk      = 1'b0;
    eff      = cur.phase;
    zs       = cur.zeros_seen;
    nts      = cur.nibbles_to_skip;
    if (item.restart) begin
      nxt.phase           = PH_ZERO;
      nxt.zeros_seen      = '0;
      nxt.nibbles_to_skip = '0;
      nxt.position        = '0;
      nxt.start_offset    = '0;
      nxt.found_opcode    = '0;
    end else if (cur.phase != PH_FOUND) begin
      // illegal codes fall back to zero hunt
      if (!(cur.phase inside {PH_OPCODE, PH_MSKIP, PH_CHANNEL, PH_CSKIP, PH_DATA})) begin
        eff = PH_ZERO;
      end
      if (skip_zero_hunt && eff == PH_ZERO) begin
        eff = PH_OPCODE;
      end
      nxt.phase = eff;
      case (eff)
        PH_ZERO: begin
          if (item.nibble == NIBBLE_ZERO) begin
            if (zs < ZERO_RUN) begin
              zs = zs + 2'd1;
            end
            nxt.zeros_seen = zs;
            if (zs >= ZERO_RUN) begin
              nxt.phase = PH_OPCODE;
            end
          end else begin
            brk = 1'b1;
          end
        end
        PH_OPCODE: begin
          if (item.nibble != NIBBLE_ZERO) begin
            nxt.start_offset = cur.position;
            if (item.nibble == MASTER_OP) begin
              nxt.phase           = PH_MSKIP;
              nxt.nibbles_to_skip = SKIP_COUNT;
            end else if (item.nibble == CHANNEL_OP) begin
              nxt.phase           = PH_CSKIP;
              nxt.nibbles_to_skip = SKIP_COUNT;
            end else if (is_data_opcode(item.nibble)) begin
              nxt.phase        = PH_FOUND;
              nxt.found_opcode = item.nibble;
            end else begin
              brk = 1'b1;
            end
          end
        end
        PH_MSKIP, PH_CSKIP: begin
          if (nts != 2'd0) begin
            nts = nts - 2'd1;
          end
          nxt.nibbles_to_skip = nts;
          if (nts == 2'd0) begin
            nxt.phase = (eff == PH_MSKIP) ? PH_CHANNEL : PH_DATA;
          end
        end
        PH_CHANNEL: begin
          if (item.nibble == CHANNEL_OP) begin
            nxt.phase           = PH_CSKIP;
            nxt.nibbles_to_skip = SKIP_COUNT;
          end else begin
            brk = 1'b1;
          end
        end
        PH_DATA: begin
          if (is_data_opcode(item.nibble)) begin
            nxt.phase        = PH_FOUND;
            nxt.found_opcode = item.nibble;
          end else begin
            brk = 1'b1;
          end
        end
        default: begin
          brk = 1'b1;
        end
      endcase
      if (brk) begin
        nxt.phase           = PH_ZERO;
        nxt.zeros_seen      = '0;
        nxt.start_offset    = '0;
        nxt.nibbles_to_skip = '0;
      end
      // saturating position
      if (cur.position != '1) begin
        nxt.position = cur.position + 1'b1;
      end
    end
  end

  assign off_wide = 32'(nxt.start_offset);

  always_comb begin
    if (nxt.phase == PH_FOUND) begin
      result.hdr_found     = 1'b1;
      result.header_offset = off_wide[OFFSET_BITS-1:0];
      result.data_opcode   = nxt.found_opcode;
    end else begin
      result = '0;
    end
  end

endmodule

>>> rtl/thss_checker.sv
// ----------------------------------------------------------------------------
// thss_checker
// Port-level checks for the trace header sync search unit.
// ----------------------------------------------------------------------------
module thss_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input thss_pkg::out_item_t out_item
);
  import thss_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed");

  // no header means empty fields
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.hdr_found |->
      out_item.header_offset == '0 && out_item.data_opcode == '0)
    else $error("fields set without a header");

  // a found header carries a data opcode
  a_data_op: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.hdr_found |->
      out_item.data_opcode >= DATA_OP_MIN && out_item.data_opcode <= DATA_OP_MAX)
    else $error("header with bad data opcode");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind trace_header_sync_search_unit thss_checker u_thss_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

>>> tb/trace_header_sync_search_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_header_sync_search_unit_tb
// Self-checking bench for the nibble-serial trace header search. A short
// table of directed rows comes first. Random header hunts follow under both
// search modes, with random flow control on both channels. Every result item
// is compared, field by field, with a typed-in result or a behavioral search model.
// ----------------------------------------------------------------------------
module trace_header_sync_search_unit_tb;
  import thss_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 7;
  localparam int IDLE_LIMIT   = 1000;  // cycles with no item moving on either side
  localparam int PHASE_GOAL   = 306;   // items per random phase, ~1250 in all
  localparam int LONG_HOLD    = 60;    // receiver hold-off, long enough to back up the input

  // data opcodes used by name in the directed rows
  localparam logic [3:0] OP_D8      = 4'h4;
  localparam logic [3:0] OP_D8_ALT  = 4'h8;
  localparam logic [3:0] OP_D64     = 4'h7;
  localparam logic [3:0] OP_D64_ALT = 4'hB;

  localparam out_item_t NO_HEADER = '0;

  typedef struct packed {
    logic       skip;     // search mode for this row
    logic [3:0] nibble;
    logic       restart;
    logic       known;    // 1: res below is the expected result, else the model decides
    out_item_t  res;
  } dir_row_t;

  typedef struct packed {
    logic      known;
    out_item_t res;
  } typed_report_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      wr_en;
  logic      wr_data;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  trace_header_sync_search_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_data  (wr_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Search model state (mirrors the block's state, own copy of the register)
  // --------------------------------------------------------------------------
  phase_t                   ph;
  logic [1:0]               zeros_run;
  logic [1:0]               skip_left;
  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] start_pos;
  logic [3:0]               found_op;
  logic                     skip_hunt;

  out_item_t     header_reports_due[$];  // predicted results, oldest first
  typed_report_t typed_reports[$];       // per offered item: typed-in result, if any
  int            items_sent;
  int            reports_checked;
  int            mismatches;
  int            idle_cycles;
  bit            quiet;                  // no idling on either side
  bit            long_hold_req;

  // Directed rows. Offsets count nibbles since the last restart.
  dir_row_t directed_rows [25] = '{
    // zero hunt mode: full header with master and channel opcodes
    '{1'b0, 4'h0,        1'b1, 1'b1, NO_HEADER},
    '{1'b0, NIBBLE_ZERO, 1'b0, 1'b0, NO_HEADER},
    '{1'b0, NIBBLE_ZERO, 1'b0, 1'b0, NO_HEADER},
    '{1'b0, NIBBLE_ZERO, 1'b0, 1'b0, NO_HEADER},
    '{1'b0, NIBBLE_ZERO, 1'b0, 1'b0, NO_HEADER},  // extra zero, ignored
    '{1'b0, MASTER_OP,   1'b0, 1'b0, NO_HEADER},
    '{1'b0, 4'hF,        1'b0, 1'b0, NO_HEADER},
    '{1'b0, 4'hF,        1'b0, 1'b0, NO_HEADER},
    '{1'b0, CHANNEL_OP,  1'b0, 1'b0, NO_HEADER},
    '{1'b0, 4'hA,        1'b0, 1'b0, NO_HEADER},
    '{1'b0, 4'h5,        1'b0, 1'b0, NO_HEADER},
    '{1'b0, OP_D8,       1'b0, 1'b1, '{1'b1, OFFSET_BITS'(4), OP_D8}},
    '{1'b0, 4'hF,        1'b0, 1'b1, '{1'b1, OFFSET_BITS'(4), OP_D8}},  // held
    // broken pattern, then a data opcode with no zero run in front
    '{1'b0, 4'h0,        1'b1, 1'b1, NO_HEADER},
    '{1'b0, NIBBLE_ZERO, 1'b0, 1'b0, NO_HEADER},
    '{1'b0, NIBBLE_ZERO, 1'b0, 1'b0, NO_HEADER},
    '{1'b0, NIBBLE_ZERO, 1'b0, 1'b0, NO_HEADER},
    '{1'b0, 4'h2,        1'b0, 1'b1, NO_HEADER},
    '{1'b0, OP_D64_ALT,  1'b0, 1'b1, NO_HEADER},
    // start-at-once mode
    '{1'b1, 4'hF,        1'b1, 1'b1, NO_HEADER},
    '{1'b1, NIBBLE_ZERO, 1'b0, 1'b0, NO_HEADER},
    '{1'b1, OP_D64,      1'b0, 1'b1, '{1'b1, OFFSET_BITS'(1), OP_D64}},
    '{1'b1, 4'h0,        1'b1, 1'b1, NO_HEADER},
    '{1'b1, 4'hC,        1'b0, 1'b1, NO_HEADER},  // break, hunt resumes at opcode
    '{1'b1, OP_D8_ALT,   1'b0, 1'b1, '{1'b1, OFFSET_BITS'(1), OP_D8_ALT}}
  };

  function automatic void drop_pattern();
    ph        = PH_ZERO;
    zeros_run = '0;
    skip_left = '0;
    start_pos = '0;
  endfunction

  function automatic void clear_search();
    drop_pattern();
    pos      = '0;
    found_op = '0;
  endfunction

  // One step of the header search for an accepted item; returns the result.
  function automatic out_item_t predict_header_search(in_item_t it);
    logic      is_data;
    out_item_t res;
    is_data = (it.nibble >= DATA_OP_MIN) && (it.nibble <= DATA_OP_MAX);
    if (it.restart) begin
      clear_search();
    end else if (ph != PH_FOUND) begin
      if (skip_hunt && ph == PH_ZERO) ph = PH_OPCODE;
      case (ph)
        PH_ZERO: begin
          if (it.nibble == NIBBLE_ZERO) begin
            if (zeros_run != ZERO_RUN) zeros_run++;
            if (zeros_run == ZERO_RUN) ph = PH_OPCODE;
          end else begin
            drop_pattern();
          end
        end
        PH_OPCODE: begin
          // zeros here are just more sync, the first nonzero nibble marks the offset
          if (it.nibble != NIBBLE_ZERO) begin
            start_pos = pos;
            if (it.nibble == MASTER_OP) begin
              ph        = PH_MSKIP;
              skip_left = SKIP_COUNT;
            end else if (it.nibble == CHANNEL_OP) begin
              ph        = PH_CSKIP;
              skip_left = SKIP_COUNT;
            end else if (is_data) begin
              found_op = it.nibble;
              ph       = PH_FOUND;
            end else begin
              drop_pattern();
            end
          end
        end
        PH_MSKIP, PH_CSKIP: begin
          if (skip_left != 0) skip_left--;
          if (skip_left == 0) ph = (ph == PH_MSKIP) ? PH_CHANNEL : PH_DATA;
        end
        PH_CHANNEL: begin
          if (it.nibble == CHANNEL_OP) begin
            ph        = PH_CSKIP;
            skip_left = SKIP_COUNT;
          end else begin
            drop_pattern();
          end
        end
        default: begin
          if (is_data) begin
            found_op = it.nibble;
            ph       = PH_FOUND;
          end else begin
            drop_pattern();
          end
        end
      endcase
      if (pos != '1) pos++;  // saturates at the top
    end
    res = NO_HEADER;
    if (ph == PH_FOUND) begin
      res.hdr_found     = 1'b1;
      res.header_offset = OFFSET_BITS'(start_pos);
      res.data_opcode   = found_op;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: predict on input acceptance, compare on result acceptance.
  // Values read at the edge are the ones that stood before it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    typed_report_t tr;
    out_item_t     want;
    out_item_t     got;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        tr   = typed_reports.pop_front();
        want = predict_header_search(in_item);
        header_reports_due.insert(header_reports_due.size(), tr.known ? tr.res : want);
      end
      if (out_valid && !out_stall) begin
        got = out_item;
        if (header_reports_due.size() == 0) begin
          $display("%0t: result with nothing expected: found %0d offset %0d opcode %0h",
                   $time, got.hdr_found, got.header_offset, got.data_opcode);
          mismatches++;
        end else begin
          want = header_reports_due.pop_front();
          if (got.hdr_found !== want.hdr_found) begin
            $display("%0t: hdr_found expected %0d, got %0d",
                     $time, want.hdr_found, got.hdr_found);
            mismatches++;
          end
          if (got.header_offset !== want.header_offset) begin
            $display("%0t: header_offset expected %0d, got %0d",
                     $time, want.header_offset, got.header_offset);
            mismatches++;
          end
          if (got.data_opcode !== want.data_opcode) begin
            $display("%0t: data_opcode expected %0h, got %0h",
                     $time, want.data_opcode, got.data_opcode);
            mismatches++;
          end
        end
        reports_checked++;
      end
    end
  end

  // Watchdog: too long with no item moving ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("trace_header_sync_search_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stall bursts, plus one long hold-off on request so
  // the block fills up and raises in_stall while the sender keeps offering.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  function automatic logic [3:0] rand_nibble();
    return 4'($urandom);
  endfunction

  // Offer one item, with an optional idle burst first, and hold it until taken.
  task automatic send_item(logic [3:0] nib, logic rs, logic known = 1'b0,
                           out_item_t res = NO_HEADER);
    typed_report_t tr;
    int            gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tr.known = known;
    tr.res   = res;
    typed_reports.insert(typed_reports.size(), tr);
    in_valid <= 1'b1;
    in_item  <= '{nibble: nib, restart: rs};
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Stop offering and wait for every result still owed.
  task automatic settle();
    in_valid <= 1'b0;
    while (reports_checked != items_sent) @(posedge clk);
    @(posedge clk);
  endtask

  // Mode change only with the block drained.
  task automatic write_skip(logic v);
    settle();
    wr_en   <= 1'b1;
    wr_data <= v;
    @(posedge clk);
    wr_en     <= 1'b0;
    skip_hunt = v;
  endtask

  // Mostly well-formed: restart, zero run, optional master and channel parts,
  // data opcode, then some trailing nibbles that a found header ignores.
  // A few slots are corrupted so broken headers show up too.
  task automatic send_header_try();
    logic master;
    logic channel;
    if ($urandom_range(0, 4) != 0) send_item(rand_nibble(), 1'b1);
    repeat (skip_hunt ? $urandom_range(0, 2) : $urandom_range(2, 6))
      send_item(NIBBLE_ZERO, 1'b0);
    master  = ($urandom_range(0, 2) == 0);
    channel = master || ($urandom_range(0, 1) == 1);
    if (master) begin
      send_item(MASTER_OP, 1'b0);
      send_item(rand_nibble(), 1'b0);
      send_item(rand_nibble(), 1'b0);
    end
    if (channel) begin
      send_item(($urandom_range(0, 9) == 0) ? rand_nibble() : CHANNEL_OP, 1'b0);
      send_item(rand_nibble(), 1'b0);
      send_item(rand_nibble(), 1'b0);
    end
    send_item(($urandom_range(0, 9) == 0) ? rand_nibble()
                                          : 4'($urandom_range(DATA_OP_MIN, DATA_OP_MAX)),
              1'b0);
    repeat ($urandom_range(0, 3)) send_item(rand_nibble(), 1'b0);
  endtask

  task automatic run_random(int goal);
    int stop_at;
    stop_at = items_sent + goal;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        // raw noise with the odd restart
        repeat ($urandom_range(1, 8)) send_item(rand_nibble(), $urandom_range(0, 9) == 0);
      end else begin
        send_header_try();
      end
    end
  endtask

  initial begin : stimulus
    rst           = 1'b1;
    wr_en         = 1'b0;
    wr_data       = 1'b0;
    in_valid      = 1'b0;
    in_item       = '0;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    idle_cycles   = 0;
    clear_search();
    skip_hunt = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_skip(1'b0);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].skip != skip_hunt) write_skip(directed_rows[i].skip);
      send_item(directed_rows[i].nibble, directed_rows[i].restart,
                directed_rows[i].known, directed_rows[i].res);
    end

    // random phases alternate the search mode; the first opens with the long hold
    write_skip(1'b0);
    long_hold_req = 1'b1;
    run_random(PHASE_GOAL);
    write_skip(1'b1);
    run_random(PHASE_GOAL);
    write_skip(1'b0);
    run_random(PHASE_GOAL);

    // last part runs with no idling
    write_skip(1'b1);
    quiet = 1'b1;
    run_random(PHASE_GOAL);

    settle();
    repeat (3) @(posedge clk);
    if (mismatches == 0) begin
      $display("trace_header_sync_search_unit test passed");
    end else begin
      $display("trace_header_sync_search_unit test failed");
    end
    $finish;
  end

endmodule
